[hdl/psd_pkg.sv]
// Package with widths, types and helper functions of the point to segment distance unit.
`timescale 1ns / 1ps
package psd_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int PROD_W  = 66;
  localparam int L2_W    = 66;
  localparam int DOT_W   = 67;
  localparam int OFF_W   = 33;
  localparam int ERR_W   = 35;
  localparam int SQ_W    = 70;
  localparam int ROOT_W  = 35;
  localparam int ACC_W   = 71;
  localparam int DIST_W  = 33;

  typedef logic [2:0][COORD_W-1:0] coord_vec_t;
  typedef logic [2:0][DIFF_W-1:0]  diff_vec_t;

  typedef struct packed {
    diff_vec_t d;
    diff_vec_t w;
  } geom_t;

  typedef struct packed {
    logic degen;
    logic nonpos;
    logic ge;
  } flags_t;

  function automatic logic signed [PROD_W-1:0] mul_diff(input logic signed [DIFF_W-1:0] a,
                                                        input logic signed [DIFF_W-1:0] b);
    mul_diff = a * b;
  endfunction

  function automatic logic signed [SQ_W-1:0] mul_err(input logic signed [ERR_W-1:0] a,
                                                     input logic signed [ERR_W-1:0] b);
    mul_err = a * b;
  endfunction

endpackage

[hdl/psd_in_if.sv]
// Input channel carrying the query point and the segment endpoints.
`timescale 1ns / 1ps
interface psd_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;

  modport source (output valid, point_x, point_y, point_z, start_x, start_y, start_z,
                  end_x, end_y, end_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, start_x, start_y, start_z,
                end_x, end_y, end_z, output ready);
endinterface

[hdl/psd_out_if.sv]
// Output channel carrying the distance and the zero-length flag.
`timescale 1ns / 1ps
interface psd_out_if;
  logic        valid;
  logic        ready;
  logic [32:0] distance;
  logic        degenerate;

  modport source (output valid, distance, degenerate, input ready);
  modport sink (input valid, distance, degenerate, output ready);
endinterface

[hdl/psd_front.sv]
// Front stages: differences, products, squared length, dot product and t classification.
`timescale 1ns / 1ps
module psd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  psd_pkg::coord_vec_t            point,
  input  psd_pkg::coord_vec_t            start,
  input  psd_pkg::coord_vec_t            seg_end,
  output logic                           out_valid,
  output psd_pkg::geom_t                 geom,
  output psd_pkg::flags_t                flags,
  output logic [psd_pkg::L2_W-1:0]       l2,
  output logic [psd_pkg::L2_W-1:0]       rem
);
  import psd_pkg::*;

  logic                     v1, v2, v3, v4;
  geom_t                    g1, g2, g3, g4;
  geom_t                    g1_next;
  logic [2:0][PROD_W-1:0]   dd2, wd2, dd2_next, wd2_next;
  logic [L2_W-1:0]          l2_3, l2_3_next, l2_4;
  logic signed [DOT_W-1:0]  dot3, dot3_next;
  logic [L2_W-1:0]          rem4;
  flags_t                   f4, f4_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g1_next.d[i] = DIFF_W'($signed(seg_end[i])) - DIFF_W'($signed(start[i]));
      g1_next.w[i] = DIFF_W'($signed(point[i])) - DIFF_W'($signed(start[i]));
      dd2_next[i]  = mul_diff($signed(g1.d[i]), $signed(g1.d[i]));
      wd2_next[i]  = mul_diff($signed(g1.w[i]), $signed(g1.d[i]));
    end
    l2_3_next = dd2[0][L2_W-1:0] + dd2[1][L2_W-1:0] + dd2[2][L2_W-1:0];
    dot3_next = DOT_W'($signed(wd2[0])) + DOT_W'($signed(wd2[1])) + DOT_W'($signed(wd2[2]));
    f4_next.degen  = (l2_3 == '0);
    f4_next.nonpos = dot3[DOT_W-1] || (dot3 == '0);
    f4_next.ge     = (dot3 >= $signed({1'b0, l2_3}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1   <= g1_next;
      g2   <= g1;
      dd2  <= dd2_next;
      wd2  <= wd2_next;
      g3   <= g2;
      l2_3 <= l2_3_next;
      dot3 <= dot3_next;
      g4   <= g3;
      l2_4 <= l2_3;
      rem4 <= dot3[L2_W-1:0];
      f4   <= f4_next;
    end
  end

  assign out_valid = v4;
  assign geom      = g4;
  assign flags     = f4;
  assign l2        = l2_4;
  assign rem       = rem4;
endmodule

[hdl/psd_div.sv]
// Restoring divider pipeline, one quotient bit of t per stage.
`timescale 1ns / 1ps
module psd_div #(
  parameter int TF = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  psd_pkg::geom_t              geom,
  input  psd_pkg::flags_t             flags,
  input  logic [psd_pkg::L2_W-1:0]    l2,
  input  logic [psd_pkg::L2_W-1:0]    rem,
  output logic                        out_valid,
  output psd_pkg::geom_t              geom_o,
  output psd_pkg::flags_t             flags_o,
  output logic [TF-1:0]               quot
);
  import psd_pkg::*;

  logic            v   [TF+1];
  geom_t           g   [TF+1];
  flags_t          f   [TF+1];
  logic [L2_W-1:0] l2s [TF+1];
  logic [L2_W-1:0] r   [TF+1];
  logic [TF-1:0]   q   [TF+1];

  assign v[0]   = in_valid;
  assign g[0]   = geom;
  assign f[0]   = flags;
  assign l2s[0] = l2;
  assign r[0]   = rem;
  assign q[0]   = '0;

  for (genvar k = 0; k < TF; k++) begin : g_stage
    logic [L2_W:0]   sh, diff;
    logic            take;
    logic [L2_W-1:0] r_next;

    always_comb begin
      sh     = {r[k], 1'b0};
      diff   = sh - {1'b0, l2s[k]};
      take   = (sh >= {1'b0, l2s[k]});
      r_next = take ? diff[L2_W-1:0] : sh[L2_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        g[k+1]   <= g[k];
        f[k+1]   <= f[k];
        l2s[k+1] <= l2s[k];
        r[k+1]   <= r_next;
        q[k+1]   <= {q[k][TF-2:0], take};
      end
    end
  end

  assign out_valid = v[TF];
  assign geom_o    = g[TF];
  assign flags_o   = f[TF];
  assign quot      = q[TF];
endmodule

[hdl/psd_back.sv]
// Back stages: clamped t, projection offsets, error vector and sum of squares.
`timescale 1ns / 1ps
module psd_back #(
  parameter int TF = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  psd_pkg::geom_t            geom,
  input  psd_pkg::flags_t           flags,
  input  logic [TF-1:0]             quot,
  output logic                      out_valid,
  output logic [psd_pkg::SQ_W-1:0]  sq,
  output logic                      degen
);
  import psd_pkg::*;

  localparam logic [TF:0] T_ONE = {1'b1, {TF{1'b0}}};

  logic                   v1, v2, v3, v4, v5;
  logic                   dg1, dg2, dg3, dg4, dg5;
  geom_t                  g1;
  logic [TF:0]            t1, t1_next;
  diff_vec_t              w2;
  logic [2:0]             dneg2, dneg2_next;
  logic [2:0][OFF_W-1:0]  off2, off2_next;
  logic [2:0][ERR_W-1:0]  e3, e3_next;
  logic [2:0][SQ_W-1:0]   s4, s4_next;
  logic [SQ_W-1:0]        sum5, sum5_next;
  logic [DIFF_W-1:0]      mag [3];
  logic [TF+DIFF_W:0]     prod [3];

  always_comb begin
    if (flags.degen || flags.nonpos) begin
      t1_next = '0;
    end else if (flags.ge) begin
      t1_next = T_ONE;
    end else begin
      t1_next = {1'b0, quot};
    end
    for (int i = 0; i < 3; i++) begin
      dneg2_next[i] = g1.d[i][DIFF_W-1];
      mag[i]        = dneg2_next[i] ? (DIFF_W'(0) - g1.d[i]) : g1.d[i];
      prod[i]       = t1 * mag[i];
      off2_next[i]  = prod[i][TF+OFF_W-1:TF];
      e3_next[i]    = dneg2[i] ? (ERR_W'($signed(w2[i])) + ERR_W'(off2[i]))
                               : (ERR_W'($signed(w2[i])) - ERR_W'(off2[i]));
      s4_next[i]    = mul_err($signed(e3[i]), $signed(e3[i]));
    end
    sum5_next = s4[0] + s4[1] + s4[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1    <= geom;
      t1    <= t1_next;
      dg1   <= flags.degen;
      w2    <= g1.w;
      dneg2 <= dneg2_next;
      off2  <= off2_next;
      dg2   <= dg1;
      e3    <= e3_next;
      dg3   <= dg2;
      s4    <= s4_next;
      dg4   <= dg3;
      sum5  <= sum5_next;
      dg5   <= dg4;
    end
  end

  assign out_valid = v5;
  assign sq        = sum5;
  assign degen     = dg5;
endmodule

[hdl/psd_sqrt.sv]
// Integer square root pipeline, one root bit per stage from the top bit down.
`timescale 1ns / 1ps
module psd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [psd_pkg::SQ_W-1:0]      sq,
  input  logic                          degen,
  output logic                          out_valid,
  output logic [psd_pkg::DIST_W-1:0]    distance,
  output logic                          degen_o
);
  import psd_pkg::*;

  logic              v   [ROOT_W+1];
  logic              dg  [ROOT_W+1];
  logic [SQ_W-1:0]   n   [ROOT_W+1];
  logic [ROOT_W-1:0] res [ROOT_W+1];
  logic [ACC_W-1:0]  acc [ROOT_W+1];

  assign v[0]   = in_valid;
  assign dg[0]  = degen;
  assign n[0]   = sq;
  assign res[0] = '0;
  assign acc[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [ACC_W-1:0] cand_sq;
    logic             take;

    always_comb begin
      cand_sq = acc[k] + (ACC_W'(res[k]) << (B + 1)) + (ACC_W'(1) << (2 * B));
      take    = (cand_sq <= ACC_W'(n[k]));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dg[k+1]  <= dg[k];
        n[k+1]   <= n[k];
        res[k+1] <= take ? (res[k] | (ROOT_W'(1) << B)) : res[k];
        acc[k+1] <= take ? cand_sq : acc[k];
      end
    end
  end

  assign out_valid = v[ROOT_W];
  assign degen_o   = dg[ROOT_W];
  assign distance  = (|res[ROOT_W][ROOT_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                     : res[ROOT_W][DIST_W-1:0];
endmodule

[hdl/point_segment_distance_3d_unit.sv]
// Throughput: one item per cycle while the output is not stalled; the divider gives one bit of t per stage and the
// square root one root bit per stage, all fully pipelined.
// A one-entry skid buffer beside the output register takes the first item that leaves the pipeline
// while the output is stalled; pipeline and input then hold until the output item is taken.
// Synchronous active-high reset clears all valid bits; no item is lost.
`timescale 1ns / 1ps
module point_segment_distance_3d_unit #(
  parameter int T_FRACTION_BITS = 16
) (
  input logic     clk,
  input logic     rst,
  psd_in_if.sink  in_ch,
  psd_out_if.source out_ch
);
  import psd_pkg::*;

  logic                en;
  coord_vec_t          point, start, seg_end;
  logic                f_valid, d_valid, b_valid, s_valid;
  geom_t               f_geom, d_geom;
  flags_t              f_flags, d_flags;
  logic [L2_W-1:0]     f_l2, f_rem;
  logic [T_FRACTION_BITS-1:0] d_quot;
  logic [SQ_W-1:0]     b_sq;
  logic                b_degen, s_degen;
  logic [DIST_W-1:0]   s_dist;
  logic                out_v, skid_v, load_out;
  logic [DIST_W-1:0]   out_dist, skid_dist;
  logic                out_degen, skid_degen;

  assign point   = {in_ch.point_z, in_ch.point_y, in_ch.point_x};
  assign start   = {in_ch.start_z, in_ch.start_y, in_ch.start_x};
  assign seg_end = {in_ch.end_z, in_ch.end_y, in_ch.end_x};

  assign en          = !skid_v;
  assign in_ch.ready = en;

  psd_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_ch.valid),
    .point(point), .start(start), .seg_end(seg_end),
    .out_valid(f_valid), .geom(f_geom), .flags(f_flags), .l2(f_l2), .rem(f_rem)
  );

  psd_div #(.TF(T_FRACTION_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .geom(f_geom), .flags(f_flags), .l2(f_l2), .rem(f_rem),
    .out_valid(d_valid), .geom_o(d_geom), .flags_o(d_flags), .quot(d_quot)
  );

  psd_back #(.TF(T_FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid),
    .geom(d_geom), .flags(d_flags), .quot(d_quot),
    .out_valid(b_valid), .sq(b_sq), .degen(b_degen)
  );

  psd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(b_valid), .sq(b_sq), .degen(b_degen),
    .out_valid(s_valid), .distance(s_dist), .degen_o(s_degen)
  );

  assign load_out = !out_v || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (load_out) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end
    end else if (s_valid) begin
      if (load_out) begin
        out_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (load_out) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (load_out) begin
        out_dist  <= skid_dist;
        out_degen <= skid_degen;
      end
    end else if (s_valid) begin
      if (load_out) begin
        out_dist  <= s_dist;
        out_degen <= s_degen;
      end else begin
        skid_dist  <= s_dist;
        skid_degen <= s_degen;
      end
    end
  end

  assign out_ch.valid      = out_v;
  assign out_ch.distance   = out_dist;
  assign out_ch.degenerate = out_degen;
endmodule

[hdl/psd_checker.sv]
// Port-level checker for the distance unit and its bind to the top level.
`timescale 1ns / 1ps
module psd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [32:0] distance,
  input logic        degenerate
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Output item dropped while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output item shown right after reset.");

  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("Input blocked without an output stall.");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input blocked while the output is empty.");

  a_deg_known: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !$isunknown(distance))
    else $error("Distance unknown on a zero-length segment item.");
endmodule

bind point_segment_distance_3d_unit psd_checker u_psd_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .distance(out_ch.distance),
  .degenerate(out_ch.degenerate)
);

[test/point_segment_distance_3d_unit_tb.sv]
// Testbench of the point to segment distance unit: random and corner-case queries against a predictor.
`timescale 1ns / 1ps

class distance_scoreboard;
  typedef struct {
    logic [32:0] distance;
    logic        degenerate;
  } dist_result_t;

  dist_result_t pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function logic [63:0] root_of(logic [127:0] n);
    logic [63:0] res;
    logic [63:0] cand;
    res = 0;
    for (int b = 40; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
    end
    return res;
  endfunction

  function void note_query(logic signed [31:0] p[3], logic signed [31:0] a[3],
                           logic signed [31:0] b[3]);
    logic signed [127:0] d[3];
    logic signed [127:0] w[3];
    logic signed [127:0] len2;
    logic signed [127:0] dot;
    logic signed [127:0] off;
    logic signed [127:0] e;
    logic [127:0] sum;
    logic [127:0] rem;
    logic [63:0] t;
    logic [63:0] root;
    dist_result_t r;
    len2 = 0;
    dot = 0;
    sum = 0;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 128'(b[i]) - 128'(a[i]);
      w[i] = 128'(p[i]) - 128'(a[i]);
      len2 = len2 + d[i] * d[i];
      dot = dot + w[i] * d[i];
    end
    r.degenerate = (len2 == 0);
    if (!r.degenerate) begin
      if (dot <= 0) t = 0;
      else if (dot >= len2) t = 64'd1 << 16;
      else begin
        rem = dot;
        for (int i = 0; i < 16; i++) begin
          rem = rem << 1;
          t = t << 1;
          if (rem >= len2) begin
            rem = rem - len2;
            t = t | 1;
          end
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      off = ($signed({64'd0, t}) * (d[i] < 0 ? -d[i] : d[i])) >>> 16;
      e = d[i] < 0 ? w[i] + off : w[i] - off;
      sum = sum + e * e;
    end
    root = root_of(sum);
    if (root > 64'h1_FFFF_FFFF) root = 64'h1_FFFF_FFFF;
    r.distance = root[32:0];
    pending.push_back(r);
  endfunction

  function void check_result(logic [32:0] distance, logic degenerate);
    dist_result_t x;
    if (pending.size() == 0) begin
      $error("unexpected result distance=%h", distance);
      errors++;
      return;
    end
    x = pending.pop_front();
    if (distance !== x.distance) begin
      $error("distance expected %h actual %h", x.distance, distance);
      errors++;
    end
    if (degenerate !== x.degenerate) begin
      $error("degenerate expected %b actual %b", x.degenerate, degenerate);
      errors++;
    end
  endfunction
endclass

module point_segment_distance_3d_unit_tb;
  logic clk = 0;
  logic rst = 1;
  logic stim_done = 0;
  psd_in_if in_ch();
  psd_out_if out_ch();
  distance_scoreboard board = new();

  point_segment_distance_3d_unit dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.point_x = 0; in_ch.point_y = 0; in_ch.point_z = 0;
    in_ch.start_x = 0; in_ch.start_y = 0; in_ch.start_z = 0;
    in_ch.end_x = 0; in_ch.end_y = 0; in_ch.end_z = 0;
    out_ch.ready = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] coord_of(int kind);
    case (kind)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 4096) - 2048;
      3: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_query(logic [31:0] v[9]);
    logic signed [31:0] p[3];
    logic signed [31:0] a[3];
    logic signed [31:0] b[3];
    for (int i = 0; i < 3; i++) begin
      p[i] = v[i];
      a[i] = v[3 + i];
      b[i] = v[6 + i];
    end
    in_ch.valid <= 1;
    in_ch.point_x <= v[0]; in_ch.point_y <= v[1]; in_ch.point_z <= v[2];
    in_ch.start_x <= v[3]; in_ch.start_y <= v[4]; in_ch.start_z <= v[5];
    in_ch.end_x <= v[6]; in_ch.end_y <= v[7]; in_ch.end_z <= v[8];
    do @(posedge clk); while (!in_ch.ready);
    board.note_query(p, a, b);
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      in_ch.valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.distance, out_ch.degenerate);
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      if (stim_done || $urandom_range(0, 9) < 6) begin
        out_ch.ready <= 1;
        @(posedge clk);
      end else begin
        gap = gap_len();
        out_ch.ready <= 0;
        repeat (gap + 1) @(posedge clk);
      end
    end
  end

  initial begin
    logic [31:0] v[9];
    int mode;
    int waited;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int k = 0; k < 24; k++) begin
      mode = k % 8;
      for (int i = 0; i < 9; i++) begin
        case (mode)
          0: v[i] = 32'h8000_0000;
          1: v[i] = 32'h7FFF_FFFF;
          2: v[i] = (i < 3) ? 32'h7FFF_FFFF : 32'h8000_0000;
          3: v[i] = (i >= 6) ? 32'h7FFF_FFFF : 32'h8000_0000;
          4: v[i] = (i >= 6) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          5: v[i] = (i < 3) ? coord_of(4) : 32'h0001_0000 * (k - 4);
          6: v[i] = (i < 3) ? 32'h0005_0000 : (i < 6 ? 32'h0 : 32'h0002_0000);
          default: v[i] = (i < 3) ? 32'hFFFB_0000 : (i < 6 ? 32'h0 : 32'h0002_0000);
        endcase
      end
      if (k >= 8 && k < 16) begin
        for (int i = 0; i < 3; i++) v[i] = coord_of(k % 5);
        for (int i = 3; i < 6; i++) v[i] = coord_of((k + 1) % 5);
        for (int i = 6; i < 9; i++) v[i] = coord_of((k + 2) % 5);
      end
      if (k >= 16) begin
        v[3] = 32'h0001_0000; v[4] = 32'h0002_0000; v[5] = 32'h0003_0000;
        v[6] = v[3] + (k - 19); v[7] = v[4]; v[8] = v[5];
        v[0] = coord_of(k % 5); v[1] = v[0] + 1; v[2] = v[0] - 1;
      end
      send_query(v);
    end
    for (int k = 0; k < 1500; k++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) v[i] = coord_of($urandom_range(0, 4));
      if (mode < 2) for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i];
      else if (mode < 4) begin
        for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i] + $urandom_range(0, 6) - 3;
      end else if (mode < 6) begin
        for (int i = 0; i < 3; i++) v[i] = v[3 + i] + ((v[6 + i] - v[3 + i]) >>> 1);
      end
      send_query(v);
      if (k == 700) begin
        in_ch.valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
      end else idle_input(gap_len());
    end
    in_ch.valid <= 0;
    stim_done = 1;
    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

[point_segment_distance_3d_unit.f]
hdl/psd_pkg.sv
hdl/psd_in_if.sv
hdl/psd_out_if.sv
hdl/psd_front.sv
hdl/psd_div.sv
hdl/psd_back.sv
hdl/psd_sqrt.sv
hdl/point_segment_distance_3d_unit.sv
hdl/psd_checker.sv
test/point_segment_distance_3d_unit_tb.sv
